// ===== sv/andres_circle_point_generator_top_assert.svh =====
// assertion macros for the circle point generator
`ifndef ANDRES_CIRCLE_POINT_GENERATOR_TOP_ASSERT_SVH
`define ANDRES_CIRCLE_POINT_GENERATOR_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define ACPG_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define ACPG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ACPG_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg)
`define ACPG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== sv/acpg_pkg.sv =====
// shared types and constants of the circle point generator
package acpg_pkg;

    localparam int RADIUS_BITS_DEF = 10;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [11:0] LAST_COLUMN_RESET = 12'd479;
    localparam logic [11:0] LAST_ROW_RESET    = 12'd271;

    localparam logic [2:0] IDX_LAST_POINT = 3'd7;

    typedef enum logic [0:0] {
        CFG_LAST_COLUMN = 1'b0,
        CFG_LAST_ROW    = 1'b1
    } t_cfg_idx;

    // queue status seen by both sides
    typedef struct packed {
        logic vld;
        logic full;
    } t_q_stat;

endpackage

// ===== sv/acpg_front.sv =====
// front end: takes words, runs the andres decision step, queues iteration records
module acpg_front #(
    parameter int RADIUS_BITS = acpg_pkg::RADIUS_BITS_DEF,
    localparam int DW = RADIUS_BITS + 4,
    localparam int RW = 41 + 2 * RADIUS_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic                i_start_req,
    input  logic                i_fill_mode,
    input  logic signed [11:0]  i_center_x,
    input  logic signed [11:0]  i_center_y,
    input  logic [9:0]          i_circle_radius,
    input  logic [15:0]         i_pixel_color,
    input  acpg_pkg::t_q_stat   i_q_stat,
    output logic                o_push,
    output logic [RW-1:0]       o_rec
);

    localparam logic signed [DW-1:0] S_ONE = 1;

    logic                   r_active, n_active;
    logic                   r_fill, n_fill;
    logic signed [DW-1:0]   r_dec, n_dec;
    logic signed [DW-1:0]   r_ox, n_ox;
    logic signed [DW-1:0]   r_oy, n_oy;
    logic [RADIUS_BITS-1:0] r_rad, n_rad;
    logic signed [11:0]     r_cx, n_cx;
    logic signed [11:0]     r_cy, n_cy;
    logic [15:0]            r_col, n_col;

    logic                   acc;
    logic [RADIUS_BITS-1:0] in_rad;
    logic [RADIUS_BITS-1:0] rad_m1;
    logic signed [DW-1:0]   in_rad_s;
    logic signed [DW-1:0]   rad_s;
    logic signed [DW-1:0]   rad_m1_s;
    logic signed [DW-1:0]   two_x;
    logic                   go_col;
    logic                   go_row;
    logic signed [DW-1:0]   st_dec;
    logic signed [DW-1:0]   st_ox;
    logic signed [DW-1:0]   st_oy;
    logic                   fin;
    logic                   refill;

    assign acc        = i_in_valid && !i_q_stat.full;
    assign o_in_stall = i_q_stat.full;

    assign in_rad   = RADIUS_BITS'(i_circle_radius);
    assign rad_m1   = r_rad - 1'b1;
    assign in_rad_s = $signed({{(DW - RADIUS_BITS){1'b0}}, in_rad});
    assign rad_s    = $signed({{(DW - RADIUS_BITS){1'b0}}, r_rad});
    assign rad_m1_s = $signed({{(DW - RADIUS_BITS){1'b0}}, rad_m1});

    // andres decision step
    assign two_x  = r_ox <<< 1;
    assign go_col = r_dec >= two_x;
    assign go_row = r_dec < ((rad_s - r_oy) <<< 1);

    always_comb begin
        priority if (go_col) begin
            st_dec = r_dec - two_x - S_ONE;
            st_ox  = r_ox + S_ONE;
            st_oy  = r_oy;
        end else if (go_row) begin
            st_dec = r_dec + (r_oy <<< 1) - S_ONE;
            st_ox  = r_ox;
            st_oy  = r_oy - S_ONE;
        end else begin
            st_dec = r_dec + ((r_oy - r_ox - S_ONE) <<< 1);
            st_ox  = r_ox + S_ONE;
            st_oy  = r_oy - S_ONE;
        end
    end

    assign fin    = st_oy < st_ox;
    assign refill = r_fill && (r_rad != '0);
    assign o_push = acc && !i_start_req && r_active;

    always_comb begin
        n_active = r_active;
        n_fill   = r_fill;
        n_dec    = r_dec;
        n_ox     = r_ox;
        n_oy     = r_oy;
        n_rad    = r_rad;
        n_cx     = r_cx;
        n_cy     = r_cy;
        n_col    = r_col;
        if (acc && i_start_req) begin
            n_active = 1'b1;
            n_fill   = i_fill_mode;
            n_cx     = i_center_x;
            n_cy     = i_center_y;
            n_col    = i_pixel_color;
            n_rad    = in_rad;
            n_ox     = '0;
            n_oy     = in_rad_s;
            n_dec    = in_rad_s - S_ONE;
        end else if (o_push) begin
            n_dec = st_dec;
            n_ox  = st_ox;
            n_oy  = st_oy;
            if (fin) begin
                if (refill) begin
                    n_rad = rad_m1;
                    n_ox  = '0;
                    n_oy  = rad_m1_s;
                    n_dec = rad_m1_s - S_ONE;
                end else begin
                    n_active = 1'b0;
                end
            end
        end
    end

    // offsets are non-negative and at most the radius while a shape runs
    assign o_rec = {r_cx, r_cy, r_col, r_ox[RADIUS_BITS-1:0], r_oy[RADIUS_BITS-1:0],
                    fin && !refill};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_fill   <= 1'b0;
        end else begin
            r_active <= n_active;
            r_fill   <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dec <= n_dec;
        r_ox  <= n_ox;
        r_oy  <= n_oy;
        r_rad <= n_rad;
        r_cx  <= n_cx;
        r_cy  <= n_cy;
        r_col <= n_col;
    end

endmodule

// ===== sv/acpg_queue.sv =====
// short first-word-fall-through queue between front and back
module acpg_queue #(
    parameter int W = 8,
    parameter int DEPTH = acpg_pkg::QUEUE_DEPTH,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [W-1:0]      i_data,
    input  logic              i_pop,
    output logic [W-1:0]      o_data,
    output acpg_pkg::t_q_stat o_stat
);

    logic [W-1:0]  r_mem [DEPTH];
    logic [AW-1:0] r_wr, n_wr;
    logic [AW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_cnt, n_cnt;

    assign o_stat.vld  = r_cnt != '0;
    assign o_stat.full = r_cnt == CW'(DEPTH);
    assign o_data      = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        unique case ({i_push, i_pop})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// ===== sv/acpg_back.sv =====
// back end: expands one iteration record into eight points through an output register
`include "andres_circle_point_generator_top_assert.svh"

module acpg_back #(
    parameter int RADIUS_BITS = acpg_pkg::RADIUS_BITS_DEF,
    localparam int RW = 41 + 2 * RADIUS_BITS,
    localparam int PW = ((RADIUS_BITS > 11) ? RADIUS_BITS : 11) + 3
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  acpg_pkg::t_q_stat  i_q_stat,
    input  logic [RW-1:0]      i_rec,
    output logic               o_pop,
    input  logic [11:0]        i_last_col,
    input  logic [11:0]        i_last_row,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [12:0] o_point_x,
    output logic signed [12:0] o_point_y,
    output logic [15:0]        o_point_color,
    output logic               o_on_screen,
    output logic               o_last_of_step,
    output logic               o_shape_done
);

    logic                   r_valid;
    logic [2:0]             r_idx;
    logic signed [12:0]     r_px;
    logic signed [12:0]     r_py;
    logic [15:0]            r_col;
    logic                   r_vis;
    logic                   r_last;
    logic                   r_done;

    logic signed [11:0]     rec_cx;
    logic signed [11:0]     rec_cy;
    logic [15:0]            rec_col;
    logic [RADIUS_BITS-1:0] rec_a;
    logic [RADIUS_BITS-1:0] rec_b;
    logic                   rec_done;

    logic                   slot_free;
    logic                   load;
    logic                   is_last;
    logic [RADIUS_BITS-1:0] u;
    logic [RADIUS_BITS-1:0] v;
    logic signed [PW-1:0]   cx_e;
    logic signed [PW-1:0]   cy_e;
    logic signed [PW-1:0]   u_e;
    logic signed [PW-1:0]   v_e;
    logic signed [PW-1:0]   px;
    logic signed [PW-1:0]   py;
    logic signed [PW-1:0]   lim_x;
    logic signed [PW-1:0]   lim_y;
    logic                   vis;

    assign {rec_cx, rec_cy, rec_col, rec_a, rec_b, rec_done} = i_rec;

    assign slot_free = !r_valid || !i_out_stall;
    assign load      = slot_free && i_q_stat.vld;
    assign is_last   = r_idx == acpg_pkg::IDX_LAST_POINT;
    assign o_pop     = load && is_last;

    // point order: bit 2 swaps the offsets, bit 1 negates x, bit 0 negates y
    assign u = r_idx[2] ? rec_b : rec_a;
    assign v = r_idx[2] ? rec_a : rec_b;

    assign cx_e  = $signed({{(PW - 12){rec_cx[11]}}, rec_cx});
    assign cy_e  = $signed({{(PW - 12){rec_cy[11]}}, rec_cy});
    assign u_e   = $signed({{(PW - RADIUS_BITS){1'b0}}, u});
    assign v_e   = $signed({{(PW - RADIUS_BITS){1'b0}}, v});
    assign lim_x = $signed({{(PW - 12){1'b0}}, i_last_col});
    assign lim_y = $signed({{(PW - 12){1'b0}}, i_last_row});

    assign px  = r_idx[1] ? cx_e - u_e : cx_e + u_e;
    assign py  = r_idx[0] ? cy_e - v_e : cy_e + v_e;
    assign vis = !px[PW-1] && !py[PW-1] && (px <= lim_x) && (py <= lim_y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (slot_free) begin
                r_valid <= i_q_stat.vld;
            end
            if (load) begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_px   <= px[12:0];
            r_py   <= py[12:0];
            r_col  <= rec_col;
            r_vis  <= vis;
            r_last <= is_last;
            r_done <= is_last && rec_done;
        end
    end

    assign o_out_valid    = r_valid;
    assign o_point_x      = r_px;
    assign o_point_y      = r_py;
    assign o_point_color  = r_col;
    assign o_on_screen    = r_vis;
    assign o_last_of_step = r_last;
    assign o_shape_done   = r_done;

    // a record stays at the queue head until its eighth point is loaded into the output register
    `ACPG_ASSERT_SAME(a_rec_held, i_clk, i_rst_n, r_idx != '0, i_q_stat.vld, "record lost mid-step")
    `ACPG_ASSERT_NEXT(a_pop_last, i_clk, i_rst_n, o_pop, r_valid && r_last, "pop without last point")
    `ACPG_ASSERT_SAME(a_done_last, i_clk, i_rst_n, r_valid && r_done, r_last, "done off step end")

endmodule

// ===== sv/andres_circle_point_generator_top.sv =====
// top level of the andres circle point generator
//
// input channel (i_in_valid / o_in_stall): a word with i_start_req high loads a
//   shape (center, radius, colour, fill flag) and gives no point; a word with
//   i_start_req low advances the active shape one iteration and gives eight
//   points, duplicates included. an advance word while no shape runs is dropped.
// output channel (o_out_valid / i_out_stall): one point per word, with the
//   on-screen flag against the display limits, last_of_step on the eighth
//   point and shape_done on the eighth point of the final iteration.
// config port: i_cfg_we writes i_cfg_data to the register at i_cfg_index
//   (last column, last row); write only while the block is idle.
// with the queue empty, an accepted advance word writes its record into the
//   queue, and its first point is then registered in the back-end output register.
// throughput: one point per cycle while i_out_stall is low, set by the
//   single output register of the back end; load words give no point.
// the front takes words while fewer than two iterations sit in the queue (the
//   one being expanded included), so a stalled receiver holds the current point
//   and stalls the front only once the queue is full.
// reset: shape inactive, queue and output empty, display limits 479 x 271.
module andres_circle_point_generator_top #(
    parameter int RADIUS_BITS = acpg_pkg::RADIUS_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // config port
    input  logic               i_cfg_we,
    input  logic [0:0]         i_cfg_index,
    input  logic [11:0]        i_cfg_data,
    // input channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_start_req,
    input  logic               i_fill_mode,
    input  logic signed [11:0] i_center_x,
    input  logic signed [11:0] i_center_y,
    input  logic [9:0]         i_circle_radius,
    input  logic [15:0]        i_pixel_color,
    // output channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [12:0] o_point_x,
    output logic signed [12:0] o_point_y,
    output logic [15:0]        o_point_color,
    output logic               o_on_screen,
    output logic               o_last_of_step,
    output logic               o_shape_done
);

    // iteration record: center x/y, colour, both offsets, done flag
    localparam int RW = 41 + 2 * RADIUS_BITS;

    logic [11:0]       r_last_col;
    logic [11:0]       r_last_row;

    logic              push;
    logic              pop;
    logic [RW-1:0]     rec_in;
    logic [RW-1:0]     rec_out;
    acpg_pkg::t_q_stat q_stat;

    // display limits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_col <= acpg_pkg::LAST_COLUMN_RESET;
            r_last_row <= acpg_pkg::LAST_ROW_RESET;
        end else if (i_cfg_we) begin
            unique case (acpg_pkg::t_cfg_idx'(i_cfg_index))
                acpg_pkg::CFG_LAST_COLUMN: r_last_col <= i_cfg_data;
                acpg_pkg::CFG_LAST_ROW:    r_last_row <= i_cfg_data;
                default:                   r_last_col <= r_last_col;
            endcase
        end
    end

    // front: shape state and decision step
    acpg_front #(
        .RADIUS_BITS(RADIUS_BITS)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_start_req     (i_start_req),
        .i_fill_mode     (i_fill_mode),
        .i_center_x      (i_center_x),
        .i_center_y      (i_center_y),
        .i_circle_radius (i_circle_radius),
        .i_pixel_color   (i_pixel_color),
        .i_q_stat        (q_stat),
        .o_push          (push),
        .o_rec           (rec_in)
    );

    // decoupling queue
    acpg_queue #(
        .W     (RW),
        .DEPTH (acpg_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (rec_in),
        .i_pop   (pop),
        .o_data  (rec_out),
        .o_stat  (q_stat)
    );

    // back: eight points per record
    acpg_back #(
        .RADIUS_BITS(RADIUS_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_stat       (q_stat),
        .i_rec          (rec_out),
        .o_pop          (pop),
        .i_last_col     (r_last_col),
        .i_last_row     (r_last_row),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_point_x      (o_point_x),
        .o_point_y      (o_point_y),
        .o_point_color  (o_point_color),
        .o_on_screen    (o_on_screen),
        .o_last_of_step (o_last_of_step),
        .o_shape_done   (o_shape_done)
    );

endmodule
